### hw/rtl/pdi_pkg.sv
// Shared types and constants for the two-wire link bit engine.
// No dependencies; imported by every RTL module of the block.
package pdi_pkg;

    localparam int unsigned BREAK_BITS   = 12;
    localparam int unsigned TURN_BITS    = 2;
    localparam int unsigned FRAME_BITS   = 12;  // start, 8 data, parity, 2 stop
    localparam int unsigned RX_DATA_BITS = 8;
    localparam int unsigned TIMEOUT_W    = 12;

    // Request codes
    localparam logic [2:0] REQ_SEND   = 3'd0;
    localparam logic [2:0] REQ_RECV   = 3'd1;
    localparam logic [2:0] REQ_BREAK  = 3'd2;
    localparam logic [2:0] REQ_IDLE   = 3'd3;
    localparam logic [2:0] REQ_RESYNC = 3'd4;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PARITY  = 2'd1;
    localparam logic [1:0] ST_FRAME   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Resync sequence stages
    localparam logic [2:0] RS_NONE   = 3'd0;
    localparam logic [2:0] RS_TURN   = 3'd1;
    localparam logic [2:0] RS_BRK1   = 3'd2;
    localparam logic [2:0] RS_IDLE1  = 3'd3;
    localparam logic [2:0] RS_BRK2   = 3'd4;
    localparam logic [2:0] RS_IDLE2  = 3'd5;

    localparam logic [7:0] RS_IDLE1_BITS = 8'd2;
    localparam logic [7:0] RS_IDLE2_BITS = 8'd4;

    // Configuration register addresses (word index)
    localparam logic REG_START_TIMEOUT = 1'b0;
    localparam logic [TIMEOUT_W-1:0] START_TIMEOUT_RST = 12'd256;

    typedef enum logic [10:0] {
        PH_IDLE    = 11'b000_0000_0001,
        PH_TURN_TX = 11'b000_0000_0010,
        PH_TX      = 11'b000_0000_0100,
        PH_TURN_RX = 11'b000_0000_1000,
        PH_HUNT    = 11'b000_0001_0000,
        PH_RXD     = 11'b000_0010_0000,
        PH_RXPAR   = 11'b000_0100_0000,
        PH_RXS1    = 11'b000_1000_0000,
        PH_RXS2    = 11'b001_0000_0000,
        PH_BRK     = 11'b010_0000_0000,
        PH_IDLEB   = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic                 driving;
        logic                 driven_level;
        phase_t               phase;
        logic [3:0]           bit_index;
        logic [TIMEOUT_W-1:0] wait_counter;
        logic [7:0]           shift_byte;
        logic                 parity_accum;
        logic [7:0]           idle_remaining;
        logic                 rx_parity_bit;
        logic                 stops_good;
        logic [2:0]           resync_stage;
    } eng_state_t;

    // Result word, lowest field last
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] rx_data;
        logic       done_res;
        logic       ready_res;
        logic       data_level;
        logic       data_drive;
        logic       clk_active;
    } eng_result_t;

    localparam eng_state_t STATE_RST = '{
        driving:        1'b0,
        driven_level:   1'b1,
        phase:          PH_IDLE,
        bit_index:      4'd0,
        wait_counter:   '0,
        shift_byte:     8'd0,
        parity_accum:   1'b0,
        idle_remaining: 8'd0,
        rx_parity_bit:  1'b0,
        stops_good:     1'b1,
        resync_stage:   RS_NONE
    };

endpackage

### hw/rtl/pdi_link_bit_engine.sv
// Top level of the two-wire link bit engine: stream ports, APB register,
// state and result registers. Depends on pdi_pkg and pdi_step.
//
//  channel   | group                 | moves                         | per word
//  ----------+-----------------------+-------------------------------+-------------
//  command   | s_tvalid/tready/tdata | one link period + command     | 1 period
//            | s_tuser               | cmd_valid, req_type           |
//  line      | m_tvalid/tready/tdata | pin levels, done, rx byte     | 1 period
//  config    | APB (psel..prdata)    | start_timeout at byte addr 0  | setup, access
//
// Flow: one word in, one word out; the result is valid in the cycle after the
// word is taken, through the result register. All the period's work runs in
// pdi_step between the engine state register and the result register, so a word can enter every cycle.
// Stalls: s_tready is high when the result register is empty or being taken
// in the same cycle; a stalled result holds off the next word until it leaves.
// Reset: rst_n clears the engine to idle with the line released, level high,
// and start_timeout back to 256.
module pdi_link_bit_engine (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] tx_byte, [15:8] idle_count, [16] data_in
    input  logic [3:0]  s_tuser,   // [0] cmd_valid, [3:1] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] clk_active, [1] data_drive, [2] data_level,
                                   // [3] ready_res, [4] done_res, [12:5] rx_data,
                                   // [14:13] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pdi_pkg::*;

    eng_state_t           st_reg;
    eng_state_t           st_next;
    eng_result_t          res_reg;
    eng_result_t          res_next;
    logic                 out_valid_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 in_take;
    logic                 cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_START_TIMEOUT);
    assign prdata = (paddr[2] == REG_START_TIMEOUT) ? {20'd0, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= START_TIMEOUT_RST;
        else if (cfg_wr)
            timeout_reg <= pwdata[TIMEOUT_W-1:0];
    end

    // ---------------- one link period ----------------
    pdi_step u_step (
        .st            (st_reg),
        .start_timeout (timeout_reg),
        .cmd_valid     (s_tuser[0]),
        .req_type      (s_tuser[3:1]),
        .tx_byte       (s_tdata[7:0]),
        .idle_count    (s_tdata[15:8]),
        .data_in       (s_tdata[16]),
        .st_next       (st_next),
        .res           (res_next)
    );

    // Take a word when the result slot is free or drains this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= STATE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                st_reg <= st_next;
            if (in_take)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

endmodule

### hw/rtl/pdi_step.sv
// One link clock period of the bit engine: next state and result word.
// Pure combinational; depends on pdi_pkg.
module pdi_step (
    input  pdi_pkg::eng_state_t  st,
    input  logic [11:0]          start_timeout,
    input  logic                 cmd_valid,
    input  logic [2:0]           req_type,
    input  logic [7:0]           tx_byte,
    input  logic [7:0]           idle_count,
    input  logic                 data_in,
    output pdi_pkg::eng_state_t  st_next,
    output pdi_pkg::eng_result_t res
);
    import pdi_pkg::*;

    eng_state_t           w;
    eng_result_t          r;
    logic                 run;
    logic                 fin;
    logic                 drv;
    logic                 b;
    logic [2:0]           sel;
    logic [TIMEOUT_W-1:0] wc_inc;
    logic [TIMEOUT_W-1:0] lim;

    always_comb
    begin
        w   = st;
        r   = '0;
        r.data_drive = st.driving;
        r.data_level = st.driven_level;
        run = 1'b0;
        fin = 1'b0;
        drv = 1'b0;
        b   = 1'b1;
        sel = 3'd0;
        wc_inc = '0;
        lim    = '0;

        // command pickup while idle
        if (st.phase == PH_IDLE)
        begin
            if (cmd_valid && (req_type <= REQ_RESYNC))
            begin
                w.bit_index    = 4'd0;
                w.resync_stage = RS_NONE;
                priority if (req_type == REQ_SEND)
                begin
                    w.shift_byte   = tx_byte;
                    w.parity_accum = 1'b0;
                    w.phase        = st.driving ? PH_TX : PH_TURN_TX;
                    run            = 1'b1;
                end
                else if (req_type == REQ_RECV)
                begin
                    w.wait_counter = '0;
                    w.phase        = st.driving ? PH_TURN_RX : PH_HUNT;
                    run            = 1'b1;
                end
                else if (req_type == REQ_BREAK)
                begin
                    w.phase = PH_BRK;
                    run     = 1'b1;
                end
                else if (req_type == REQ_IDLE)
                begin
                    if (idle_count == 8'd0)
                        r.done_res = 1'b1;
                    else
                    begin
                        w.idle_remaining = idle_count;
                        w.phase          = PH_IDLEB;
                        run              = 1'b1;
                    end
                end
                else
                begin
                    if (st.driving)
                    begin
                        w.resync_stage = RS_BRK1;
                        w.phase        = PH_BRK;
                    end
                    else
                    begin
                        w.resync_stage = RS_TURN;
                        w.phase        = PH_TURN_TX;
                    end
                    run = 1'b1;
                end
            end
        end
        else
            run = 1'b1;

        if (run)
        begin
            // sampling phases by default show the held line state
            r.clk_active = 1'b1;
            r.data_drive = w.driving;
            r.data_level = w.driven_level;
            unique case (w.phase)
                PH_TURN_TX:
                begin
                    b   = 1'b1;
                    drv = 1'b1;
                    w.bit_index = w.bit_index + 4'd1;
                    if (w.bit_index >= 4'(TURN_BITS))
                    begin
                        w.bit_index = 4'd0;
                        if (w.resync_stage == RS_TURN)
                        begin
                            w.resync_stage = RS_BRK1;
                            w.phase        = PH_BRK;
                        end
                        else
                        begin
                            w.parity_accum = 1'b0;
                            w.phase        = PH_TX;
                        end
                    end
                    w.driving = 1'b1;
                end
                PH_TX:
                begin
                    drv = 1'b1;
                    sel = w.bit_index[2:0] - 3'd1;
                    if (w.bit_index == 4'd0)
                        b = 1'b0;
                    else if (w.bit_index <= 4'd8)
                    begin
                        b = w.shift_byte[sel];
                        w.parity_accum = w.parity_accum ^ b;
                    end
                    else if (w.bit_index == 4'd9)
                        b = w.parity_accum;
                    else
                        b = 1'b1;
                    w.bit_index = w.bit_index + 4'd1;
                    if (w.bit_index >= 4'(FRAME_BITS))
                        fin = 1'b1;
                    w.driving = 1'b1;
                end
                PH_TURN_RX:
                begin
                    b   = 1'b1;
                    drv = 1'b1;
                    w.driving   = 1'b1;
                    w.bit_index = w.bit_index + 4'd1;
                    if (w.bit_index >= 4'(TURN_BITS))
                    begin
                        w.driving      = 1'b0;
                        w.bit_index    = 4'd0;
                        w.wait_counter = '0;
                        w.phase        = PH_HUNT;
                    end
                end
                PH_HUNT:
                begin
                    if (!data_in)
                    begin
                        w.phase        = PH_RXD;
                        w.bit_index    = 4'd0;
                        w.shift_byte   = 8'd0;
                        w.parity_accum = 1'b0;
                    end
                    else
                    begin
                        lim    = (start_timeout == '0) ? TIMEOUT_W'(1) : start_timeout;
                        wc_inc = w.wait_counter + TIMEOUT_W'(1);
                        w.wait_counter = wc_inc;
                        if ((wc_inc >= lim) || (wc_inc == '0))
                        begin
                            w.wait_counter = '0;
                            r.status       = ST_TIMEOUT;
                            fin            = 1'b1;
                        end
                    end
                end
                PH_RXD:
                begin
                    w.shift_byte[w.bit_index[2:0]] = w.shift_byte[w.bit_index[2:0]] | data_in;
                    w.parity_accum = w.parity_accum ^ data_in;
                    w.bit_index    = w.bit_index + 4'd1;
                    if (w.bit_index >= 4'(RX_DATA_BITS))
                    begin
                        w.bit_index = 4'd0;
                        w.phase     = PH_RXPAR;
                    end
                end
                PH_RXPAR:
                begin
                    w.rx_parity_bit = data_in;
                    w.phase         = PH_RXS1;
                end
                PH_RXS1:
                begin
                    w.stops_good = data_in;
                    w.phase      = PH_RXS2;
                end
                PH_RXS2:
                begin
                    // parity error takes precedence over a bad stop bit
                    if (w.rx_parity_bit != w.parity_accum)
                        r.status = ST_PARITY;
                    else if (!(w.stops_good && data_in))
                        r.status = ST_FRAME;
                    else
                        r.rx_data = w.shift_byte;
                    fin = 1'b1;
                end
                PH_BRK:
                begin
                    b   = 1'b0;
                    drv = 1'b1;
                    w.driving   = 1'b1;
                    w.bit_index = w.bit_index + 4'd1;
                    if (w.bit_index >= 4'(BREAK_BITS))
                    begin
                        w.bit_index = 4'd0;
                        if (w.resync_stage == RS_BRK1)
                        begin
                            w.resync_stage   = RS_IDLE1;
                            w.idle_remaining = RS_IDLE1_BITS;
                            w.phase          = PH_IDLEB;
                        end
                        else if (w.resync_stage == RS_BRK2)
                        begin
                            w.resync_stage   = RS_IDLE2;
                            w.idle_remaining = RS_IDLE2_BITS;
                            w.phase          = PH_IDLEB;
                        end
                        else
                            fin = 1'b1;
                    end
                end
                PH_IDLEB:
                begin
                    b   = 1'b1;
                    drv = 1'b1;
                    w.driving        = 1'b1;
                    w.idle_remaining = w.idle_remaining - 8'd1;
                    if (w.idle_remaining == 8'd0)
                    begin
                        if (w.resync_stage == RS_IDLE1)
                        begin
                            w.resync_stage = RS_BRK2;
                            w.bit_index    = 4'd0;
                            w.phase        = PH_BRK;
                        end
                        else
                            fin = 1'b1;
                    end
                end
                default:
                begin
                    r.clk_active = 1'b0;
                    w.phase      = PH_IDLE;
                end
            endcase

            // driving phases put the new bit on the line
            if (drv)
            begin
                w.driven_level = b;
                r.data_drive   = 1'b1;
                r.data_level   = b;
            end

            if (fin)
            begin
                r.done_res     = 1'b1;
                w.phase        = PH_IDLE;
                w.bit_index    = 4'd0;
                w.resync_stage = RS_NONE;
            end
        end

        r.ready_res = (w.phase == PH_IDLE);
        st_next = w;
        res     = r;
    end

endmodule

### hw/rtl/pdi_checker.sv
// Port-level checks for pdi_link_bit_engine, bound to the top level.
// Depends on pdi_pkg and the top level's port list.
module pdi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import pdi_pkg::*;

    // a taken command word always yields a result word next cycle
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // error status only on the final period of a command
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> m_tdata[14:13] == ST_OK)
        else $error("status without done");

    // a failed receive returns no byte
    a_err_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[14:13] != ST_OK) |-> m_tdata[12:5] == 8'd0)
        else $error("rx byte with error status");

    // a period without a clock pulse leaves the engine ready
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[3])
        else $error("engine busy in an unclocked period");

endmodule

bind pdi_link_bit_engine pdi_checker u_pdi_checker (.*);

### bench/pdi_link_bit_engine_checker.sv
// Checker for the two-wire link bit engine: models each link period from the
// command words and APB writes it sees, and compares the line words. Needs pdi_pkg.
module pdi_link_bit_engine_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] tx_byte, [15:8] idle_count, [16] data_in
    input  logic [3:0]  s_tuser,   // [0] cmd_valid, [3:1] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [0] clk_active, [1] data_drive, [2] data_level,
                                   // [3] ready_res, [4] done_res, [12:5] rx_data,
                                   // [14:13] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          words_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pdi_pkg::*;

    localparam logic [2:0] TIMEOUT_ADDR = {REG_START_TIMEOUT, 2'b00};

    eng_state_t           eng;
    logic [TIMEOUT_W-1:0] timeout_reg;
    eng_result_t          line_out;
    eng_result_t          line_got;
    eng_result_t          line_want;
    eng_result_t          line_expect_q[$];

    function automatic void drive_line(logic level);
        eng.driving         = 1'b1;
        eng.driven_level    = level;
        line_out.clk_active = 1'b1;
        line_out.data_drive = 1'b1;
        line_out.data_level = level;
    endfunction

    function automatic void sample_line();
        line_out.clk_active = 1'b1;
        line_out.data_drive = eng.driving;
        line_out.data_level = eng.driven_level;
    endfunction

    function automatic void end_command();
        line_out.done_res = 1'b1;
        eng.phase         = PH_IDLE;
        eng.bit_index     = '0;
        eng.resync_stage  = RS_NONE;
    endfunction

    // One clocked bit period of a command already under way
    function automatic void clock_bit(logic din);
        logic                 level;
        logic [TIMEOUT_W-1:0] lim;
        level = 1'b1;
        lim   = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;
        case (eng.phase)
            PH_TURN_TX:
            begin
                drive_line(1'b1);
                eng.bit_index = eng.bit_index + 4'd1;
                if (eng.bit_index >= TURN_BITS)
                begin
                    eng.bit_index = '0;
                    if (eng.resync_stage == RS_TURN)
                    begin
                        eng.resync_stage = RS_BRK1;
                        eng.phase        = PH_BRK;
                    end
                    else
                    begin
                        eng.parity_accum = 1'b0;
                        eng.phase        = PH_TX;
                    end
                end
            end
            PH_TX:
            begin
                if (eng.bit_index == 4'd0)
                    level = 1'b0;
                else if (eng.bit_index <= 4'd8)
                begin
                    level = eng.shift_byte[3'(eng.bit_index - 4'd1)];
                    eng.parity_accum = eng.parity_accum ^ level;
                end
                else if (eng.bit_index == 4'd9)
                    level = eng.parity_accum;
                drive_line(level);
                eng.bit_index = eng.bit_index + 4'd1;
                if (eng.bit_index >= FRAME_BITS)
                    end_command();
            end
            PH_TURN_RX:
            begin
                drive_line(1'b1);
                eng.bit_index = eng.bit_index + 4'd1;
                if (eng.bit_index >= TURN_BITS)
                begin
                    eng.driving      = 1'b0;
                    eng.bit_index    = '0;
                    eng.wait_counter = '0;
                    eng.phase        = PH_HUNT;
                end
            end
            PH_HUNT:
            begin
                sample_line();
                if (!din)
                begin
                    eng.phase        = PH_RXD;
                    eng.bit_index    = '0;
                    eng.shift_byte   = '0;
                    eng.parity_accum = 1'b0;
                end
                else
                begin
                    eng.wait_counter = eng.wait_counter + TIMEOUT_W'(1);
                    if (eng.wait_counter >= lim || eng.wait_counter == '0)
                    begin
                        eng.wait_counter = '0;
                        line_out.status  = ST_TIMEOUT;
                        end_command();
                    end
                end
            end
            PH_RXD:
            begin
                sample_line();
                eng.shift_byte   = eng.shift_byte | (8'(din) << eng.bit_index[2:0]);
                eng.parity_accum = eng.parity_accum ^ din;
                eng.bit_index    = eng.bit_index + 4'd1;
                if (eng.bit_index >= RX_DATA_BITS)
                begin
                    eng.bit_index = '0;
                    eng.phase     = PH_RXPAR;
                end
            end
            PH_RXPAR:
            begin
                sample_line();
                eng.rx_parity_bit = din;
                eng.phase         = PH_RXS1;
            end
            PH_RXS1:
            begin
                sample_line();
                eng.stops_good = din;
                eng.phase      = PH_RXS2;
            end
            PH_RXS2:
            begin
                sample_line();
                // parity is judged before the stop bits
                if (eng.rx_parity_bit != eng.parity_accum)
                    line_out.status = ST_PARITY;
                else if (!(eng.stops_good && din))
                    line_out.status = ST_FRAME;
                else
                    line_out.rx_data = eng.shift_byte;
                end_command();
            end
            PH_BRK:
            begin
                drive_line(1'b0);
                eng.bit_index = eng.bit_index + 4'd1;
                if (eng.bit_index >= BREAK_BITS)
                begin
                    eng.bit_index = '0;
                    if (eng.resync_stage == RS_BRK1)
                    begin
                        eng.resync_stage   = RS_IDLE1;
                        eng.idle_remaining = RS_IDLE1_BITS;
                        eng.phase          = PH_IDLEB;
                    end
                    else if (eng.resync_stage == RS_BRK2)
                    begin
                        eng.resync_stage   = RS_IDLE2;
                        eng.idle_remaining = RS_IDLE2_BITS;
                        eng.phase          = PH_IDLEB;
                    end
                    else
                        end_command();
                end
            end
            PH_IDLEB:
            begin
                drive_line(1'b1);
                eng.idle_remaining = eng.idle_remaining - 8'd1;
                if (eng.idle_remaining == '0)
                begin
                    if (eng.resync_stage == RS_IDLE1)
                    begin
                        eng.resync_stage = RS_BRK2;
                        eng.bit_index    = '0;
                        eng.phase        = PH_BRK;
                    end
                    else
                        end_command();
                end
            end
            default:
                eng.phase = PH_IDLE;
        endcase
    endfunction

    // Line word expected for one accepted link period
    function automatic eng_result_t predict_period(logic cmd_valid, logic [2:0] req,
                                                   logic [7:0] txb, logic [7:0] cnt,
                                                   logic din);
        line_out            = '0;
        line_out.data_drive = eng.driving;
        line_out.data_level = eng.driven_level;
        if (eng.phase == PH_IDLE)
        begin
            if (cmd_valid && req <= REQ_RESYNC)
            begin
                eng.bit_index    = '0;
                eng.resync_stage = RS_NONE;
                case (req)
                    REQ_SEND:
                    begin
                        eng.shift_byte   = txb;
                        eng.parity_accum = 1'b0;
                        eng.phase        = eng.driving ? PH_TX : PH_TURN_TX;
                        clock_bit(din);
                    end
                    REQ_RECV:
                    begin
                        eng.wait_counter = '0;
                        eng.phase        = eng.driving ? PH_TURN_RX : PH_HUNT;
                        clock_bit(din);
                    end
                    REQ_BREAK:
                    begin
                        eng.phase = PH_BRK;
                        clock_bit(din);
                    end
                    REQ_IDLE:
                    begin
                        if (cnt == '0)
                            line_out.done_res = 1'b1;
                        else
                        begin
                            eng.idle_remaining = cnt;
                            eng.phase          = PH_IDLEB;
                            clock_bit(din);
                        end
                    end
                    default:
                    begin
                        if (eng.driving)
                        begin
                            eng.resync_stage = RS_BRK1;
                            eng.phase        = PH_BRK;
                        end
                        else
                        begin
                            eng.resync_stage = RS_TURN;
                            eng.phase        = PH_TURN_TX;
                        end
                        clock_bit(din);
                    end
                endcase
            end
        end
        else
            clock_bit(din);
        line_out.ready_res = (eng.phase == PH_IDLE);
        return line_out;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng         = STATE_RST;
            timeout_reg = START_TIMEOUT_RST;
            line_expect_q.delete();
            fail_count    = 0;
            words_pending = 0;
        end
        else
        begin
            // results leave before this edge's command word can add one
            if (m_tvalid && m_tready)
            begin
                line_got = eng_result_t'(m_tdata[14:0]);
                if (line_expect_q.size() == 0)
                begin
                    $error("line word %h with nothing expected", m_tdata);
                    fail_count++;
                end
                else
                begin
                    line_want = line_expect_q.pop_front();
                    check_field("clk_active", 8'(line_want.clk_active),
                                8'(line_got.clk_active));
                    check_field("data_drive", 8'(line_want.data_drive),
                                8'(line_got.data_drive));
                    check_field("data_level", 8'(line_want.data_level),
                                8'(line_got.data_level));
                    check_field("ready_res",  8'(line_want.ready_res),
                                8'(line_got.ready_res));
                    check_field("done_res",   8'(line_want.done_res),
                                8'(line_got.done_res));
                    check_field("rx_data",    line_want.rx_data, line_got.rx_data);
                    check_field("status",     8'(line_want.status),
                                8'(line_got.status));
                end
            end
            if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
                timeout_reg = pwdata[TIMEOUT_W-1:0];
            if (s_tvalid && s_tready)
                line_expect_q.push_back(predict_period(s_tuser[0], s_tuser[3:1],
                                                       s_tdata[7:0], s_tdata[15:8],
                                                       s_tdata[16]));
            words_pending = line_expect_q.size();
        end
    end

endmodule

### bench/pdi_link_bit_engine_tb.sv
// Top of the bench for the two-wire link bit engine: clock, reset, command
// and APB stimulus, receiver stalls, verdict. Needs pdi_pkg and the checker.
module pdi_link_bit_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdi_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int PHASE_WORDS  = 170;   // link periods per random phase
    localparam logic [2:0] TIMEOUT_ADDR = {REG_START_TIMEOUT, 2'b00};
    localparam logic [2:0] REQ_FIRST_BAD = REQ_RESYNC + 3'd1;
    localparam logic [2:0] REQ_LAST_BAD  = 3'd7;

    // What the slave puts on the data line during a receive
    typedef enum {RX_GOOD, RX_PARITY, RX_STOP1, RX_STOP2, RX_BOTH, RX_JUNK, RX_TIMEOUT}
        rx_shape_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // [7:0] tx_byte, [15:8] idle_count, [16] data_in
    logic [3:0]  s_tuser  = '0;    // [0] cmd_valid, [3:1] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [0] clk_active, [1] data_drive, [2] data_level,
                                   // [3] ready_res, [4] done_res, [12:5] rx_data,
                                   // [14:13] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int checker_fails;
    int checker_pending;
    int cycle_count  = 0;
    int periods_sent = 0;

    bit idle_on  = 1'b1;           // random gaps on the command side
    bit stall_on = 1'b1;           // random stalls on the line side

    // Stimulus-side view of the engine, only used to shape the data line:
    // whether the master holds the line, and the hunt limit now in force.
    logic                 line_held   = 1'b0;
    logic [TIMEOUT_W-1:0] cur_timeout = START_TIMEOUT_RST;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pdi_link_bit_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pdi_link_bit_engine_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (checker_fails),
        .words_pending (checker_pending)
    );

    // Hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL pdi_link_bit_engine");
            $finish;
        end
    end

    // Line-side backpressure: m_tready drops in random bursts while stalls are on
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (stall_on && $urandom_range(0, 4) == 0)
                    hold = $urandom_range(1, 3);
            end
        end
    end

    // One link period = one command word. A gap with s_tvalid low may go
    // ahead of it; gaps do not advance the engine, only accepted words do.
    task automatic put_period(logic valid, logic [2:0] req, logic [7:0] txb,
                              logic [7:0] cnt, logic din);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, din, cnt, txb};
        s_tuser  <= {req, valid};
        do @(posedge clk); while (!s_tready);
        periods_sent++;
    endtask

    // Offers a command in its first period, then fills every busy period with
    // random command bits (which a busy engine must ignore). For a receive
    // the data line carries turnaround filler, the hunt, then the frame (none on a timeout).
    task automatic issue(logic [2:0] req, logic [7:0] txb, logic [7:0] cnt,
                         rx_shape_t shape, int hunt_wait, logic [7:0] rx_byte);
        logic line_bits[$];
        int   periods;
        int   lim;
        lim     = (cur_timeout == '0) ? 1 : int'(cur_timeout);
        periods = 1;
        case (req)
            REQ_SEND:
            begin
                periods   = int'((line_held ? 0 : TURN_BITS) + FRAME_BITS);
                line_held = 1'b1;
            end
            REQ_RECV:
            begin
                if (line_held)
                    repeat (TURN_BITS) line_bits.push_back(1'($urandom_range(0, 1)));
                if (shape == RX_TIMEOUT)
                    repeat (lim) line_bits.push_back(1'b1);
                else
                begin
                    repeat (hunt_wait) line_bits.push_back(1'b1);
                    line_bits.push_back(1'b0);       // start bit
                    if (shape == RX_JUNK)
                        repeat (RX_DATA_BITS + 3)
                            line_bits.push_back(1'($urandom_range(0, 1)));
                    else
                    begin
                        for (int i = 0; i < RX_DATA_BITS; i++)
                            line_bits.push_back(rx_byte[i]);
                        line_bits.push_back((^rx_byte) ^
                                            (shape == RX_PARITY || shape == RX_BOTH));
                        line_bits.push_back(shape != RX_STOP1);
                        line_bits.push_back(!(shape == RX_STOP2 || shape == RX_BOTH));
                    end
                end
                line_held = 1'b0;
            end
            REQ_BREAK:
            begin
                periods   = int'(BREAK_BITS);
                line_held = 1'b1;
            end
            REQ_IDLE:
            begin
                // a zero count finishes in its own period, line untouched
                if (cnt != '0)
                begin
                    periods   = int'(cnt);
                    line_held = 1'b1;
                end
            end
            REQ_RESYNC:
            begin
                periods   = int'((line_held ? 0 : TURN_BITS) + 2 * BREAK_BITS
                                 + RS_IDLE1_BITS + RS_IDLE2_BITS);
                line_held = 1'b1;
            end
            default: ;   // unknown request: not taken, one idle period
        endcase
        while (line_bits.size() < periods)
            line_bits.push_back(1'($urandom_range(0, 1)));
        put_period(1'b1, req, txb, cnt, line_bits[0]);
        for (int i = 1; i < line_bits.size(); i++)
            put_period(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       8'($urandom), 8'($urandom), line_bits[i]);
    endtask

    // Mostly complete commands with random content; a few unknown requests
    // and empty periods between them.
    task automatic run_random(int words);
        int        first;
        int        sel;
        int        lim;
        int        hunt;
        rx_shape_t shape;
        logic [7:0] cnt;
        first = periods_sent;
        lim   = (cur_timeout == '0) ? 1 : int'(cur_timeout);
        while (periods_sent - first < words)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
                issue(REQ_SEND, 8'($urandom), 8'($urandom), RX_GOOD, 0, 8'h00);
            else if (sel < 55)
            begin
                sel   = $urandom_range(0, 19);
                shape = (sel < 13)  ? RX_GOOD   :
                        (sel < 15)  ? RX_PARITY :
                        (sel == 15) ? RX_STOP1  :
                        (sel == 16) ? RX_STOP2  :
                        (sel == 17) ? RX_BOTH   :
                        (sel == 18) ? RX_JUNK   :
                        (lim <= 64) ? RX_TIMEOUT : RX_GOOD;
                // start bit mostly early, now and then on the last hunt period
                if (lim <= 64 && $urandom_range(0, 7) == 0)
                    hunt = lim - 1;
                else
                    hunt = $urandom_range(0, (lim - 1 < 5) ? lim - 1 : 5);
                issue(REQ_RECV, 8'($urandom), 8'($urandom), shape, hunt, 8'($urandom));
            end
            else if (sel < 65)
                issue(REQ_BREAK, 8'($urandom), 8'($urandom), RX_GOOD, 0, 8'h00);
            else if (sel < 80)
            begin
                sel = $urandom_range(0, 15);
                cnt = (sel == 0) ? 8'd0 :
                      (sel == 1) ? (($urandom_range(0, 3) == 0) ? 8'd255
                                                                 : 8'($urandom_range(1, 40)))
                                 : 8'($urandom_range(1, 6));
                issue(REQ_IDLE, 8'($urandom), cnt, RX_GOOD, 0, 8'h00);
            end
            else if (sel < 90)
                issue(REQ_RESYNC, 8'($urandom), 8'($urandom), RX_GOOD, 0, 8'h00);
            else if (sel < 95)
                issue(3'($urandom_range(REQ_FIRST_BAD, REQ_LAST_BAD)), 8'($urandom),
                      8'($urandom), RX_GOOD, 0, 8'h00);
            else
                put_period(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                           1'($urandom_range(0, 1)));
        end
    endtask

    // Register write only once the engine is idle and every line word is in.
    // Upper data bits are random; only the low 12 are the register.
    task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (checker_pending != 0)
            @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {20'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_timeout = value;
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, hunt limit at its reset value of 256
        issue(REQ_IDLE, 8'h3C, 8'd0, RX_GOOD, 0, 8'h00);      // zero count, line released
        for (int r = REQ_FIRST_BAD; r <= REQ_LAST_BAD; r++)   // unknown requests
            issue(3'(r), 8'hFF, 8'hFF, RX_GOOD, 0, 8'h00);
        issue(REQ_SEND, 8'h00, 8'h00, RX_GOOD, 0, 8'h00);     // with turnaround
        issue(REQ_SEND, 8'hFF, 8'hFF, RX_GOOD, 0, 8'h00);     // line already held
        issue(REQ_RECV, 8'h00, 8'h00, RX_GOOD, 0, 8'h5A);     // turn, start at once
        issue(REQ_RECV, 8'h00, 8'h00, RX_PARITY, 3, 8'hC3);
        issue(REQ_RECV, 8'h00, 8'h00, RX_STOP1, 1, 8'h81);
        issue(REQ_RECV, 8'h00, 8'h00, RX_STOP2, 2, 8'h7E);
        issue(REQ_RECV, 8'h00, 8'h00, RX_BOTH, 0, 8'h01);     // parity wins
        issue(REQ_RECV, 8'h00, 8'h00, RX_TIMEOUT, 0, 8'h00);
        issue(REQ_BREAK, 8'h00, 8'h00, RX_GOOD, 0, 8'h00);    // break from released
        issue(REQ_IDLE, 8'h00, 8'd255, RX_GOOD, 0, 8'h00);
        issue(REQ_IDLE, 8'h00, 8'd1, RX_GOOD, 0, 8'h00);
        issue(REQ_IDLE, 8'h00, 8'd0, RX_GOOD, 0, 8'h00);      // zero count, line held
        issue(REQ_RESYNC, 8'h00, 8'h00, RX_GOOD, 0, 8'h00);   // from held line
        issue(REQ_RECV, 8'h00, 8'h00, RX_GOOD, 255, 8'hFF);   // start on last hunt period
        issue(REQ_RESYNC, 8'h00, 8'h00, RX_GOOD, 0, 8'h00);   // from released line
        issue(REQ_SEND, 8'hA5, 8'h00, RX_GOOD, 0, 8'h00);
        issue(REQ_RECV, 8'h00, 8'h00, RX_JUNK, 4, 8'h00);
        issue(REQ_RECV, 8'h00, 8'h00, RX_GOOD, 0, 8'h00);

        // Random phases across several hunt limits
        write_timeout(TIMEOUT_W'(1));
        run_random(PHASE_WORDS);
        write_timeout(TIMEOUT_W'(0));                         // acts as a limit of one
        run_random(PHASE_WORDS);
        write_timeout('1);
        run_random(PHASE_WORDS);
        write_timeout(TIMEOUT_W'($urandom_range(2, 64)));
        run_random(PHASE_WORDS);

        // Last part runs with no gaps and no stalls
        write_timeout(TIMEOUT_W'($urandom_range(2, 16)));
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_random(PHASE_WORDS);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (checker_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (checker_fails == 0)
            $display("PASS pdi_link_bit_engine");
        else
            $display("FAIL pdi_link_bit_engine");
        $finish;
    end

endmodule

### pdi_link_bit_engine.f
hw/rtl/pdi_pkg.sv
hw/rtl/pdi_step.sv
hw/rtl/pdi_link_bit_engine.sv
hw/rtl/pdi_checker.sv
bench/pdi_link_bit_engine_checker.sv
bench/pdi_link_bit_engine_tb.sv
